### sv/pcr_pkg.sv
// Shared types and constants for the clock page replacement block.
package pcr_pkg;

  localparam int MAX_FRAMES  = 64;
  localparam int FRAME_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W       = $clog2(MAX_FRAMES + 1);
  localparam int PAGE_W      = 32;
  localparam int CFG_W       = 7;
  localparam int FRAME_IDX_W = 6;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_MISS,
    ST_WRAP,
    ST_SWEEP,
    ST_DONE
  } pcr_state_t;

  typedef struct packed {
    logic              fault;
    logic [PAGE_W-1:0] page;
    logic [FRAME_W-1:0] frame;
  } pcr_result_t;

endpackage

### sv/pcr_ram.sv
// Generic single write port, single read port RAM with registered read data.
module pcr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### sv/pcr_engine.sv
// Lookup and replacement sequencer: frame memory scan, reference bits, clock hand.
module pcr_engine (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [pcr_pkg::PAGE_W-1:0] in_page,
  input  logic [pcr_pkg::CNT_W-1:0]  cap,
  output logic                      res_valid,
  input  logic                      res_ready,
  output pcr_pkg::pcr_result_t       res
);

  import pcr_pkg::*;

  pcr_state_t          state_r, state_nxt;
  logic [PAGE_W-1:0]   page_r, page_nxt;
  logic [FRAME_W-1:0]  idx_r, idx_nxt;
  logic [FRAME_W-1:0]  hand_r, hand_nxt;
  logic [FRAME_W-1:0]  h_r, h_nxt;
  logic [FRAME_W-1:0]  frame_r, frame_nxt;
  logic                fault_r, fault_nxt;
  logic [CNT_W-1:0]    filled_r, filled_nxt;
  logic [MAX_FRAMES-1:0] refb_r, refb_nxt;

  logic [CNT_W-1:0]    occupied;
  logic [CNT_W-1:0]    idx_inc;
  logic [CNT_W-1:0]    h_inc;
  logic [PAGE_W-1:0]   rd_data;
  logic                wr_en;
  logic [FRAME_W-1:0]  wr_addr;

  pcr_ram #(
    .WIDTH (PAGE_W),
    .DEPTH (MAX_FRAMES),
    .AW    (FRAME_W)
  ) u_frames (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (page_r),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  assign occupied = (filled_r < cap) ? filled_r : cap;
  assign idx_inc  = CNT_W'(idx_r) + CNT_W'(1);
  assign h_inc    = CNT_W'(h_r) + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      hand_r   <= '0;
      filled_r <= '0;
      refb_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      hand_r   <= hand_nxt;
      filled_r <= filled_nxt;
      refb_r   <= refb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r  <= page_nxt;
    idx_r   <= idx_nxt;
    h_r     <= h_nxt;
    frame_r <= frame_nxt;
    fault_r <= fault_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    page_nxt   = page_r;
    idx_nxt    = idx_r;
    h_nxt      = h_r;
    frame_nxt  = frame_r;
    fault_nxt  = fault_r;
    hand_nxt   = hand_r;
    filled_nxt = filled_r;
    refb_nxt   = refb_r;
    wr_en      = 1'b0;
    wr_addr    = h_r;
    in_ready   = 1'b0;
    res_valid  = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          page_nxt  = in_page;
          idx_nxt   = '0;
          state_nxt = (occupied == '0) ? ST_MISS : ST_RD;
        end
      end
      ST_RD: begin
        // read data for idx_r lands next cycle
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (rd_data == page_r) begin
          refb_nxt[idx_r] = 1'b1;
          frame_nxt       = idx_r;
          fault_nxt       = 1'b0;
          state_nxt       = ST_DONE;
        end else if (idx_inc == occupied) begin
          state_nxt = ST_MISS;
        end else begin
          idx_nxt   = FRAME_W'(idx_inc);
          state_nxt = ST_RD;
        end
      end
      ST_MISS: begin
        fault_nxt = 1'b1;
        if (filled_r < cap) begin
          wr_en                          = 1'b1;
          wr_addr                        = FRAME_W'(filled_r);
          refb_nxt[FRAME_W'(filled_r)]   = 1'b1;
          frame_nxt                      = FRAME_W'(filled_r);
          filled_nxt                     = filled_r + CNT_W'(1);
          state_nxt                      = ST_DONE;
        end else begin
          h_nxt     = hand_r;
          state_nxt = ST_WRAP;
        end
      end
      ST_WRAP: begin
        // fold the hand into range after the capacity was lowered
        if (CNT_W'(h_r) >= cap) begin
          h_nxt = FRAME_W'(CNT_W'(h_r) - cap);
        end else begin
          state_nxt = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (!refb_r[h_r]) begin
          wr_en         = 1'b1;
          wr_addr       = h_r;
          refb_nxt[h_r] = 1'b1;
          frame_nxt     = h_r;
          hand_nxt      = (h_inc == cap) ? '0 : FRAME_W'(h_inc);
          state_nxt     = ST_DONE;
        end else begin
          refb_nxt[h_r] = 1'b0;
          h_nxt         = (h_inc == cap) ? '0 : FRAME_W'(h_inc);
        end
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign res.fault = fault_r;
  assign res.page  = page_r;
  assign res.frame = frame_r;

endmodule

### sv/clock_page_replacement.sv
// Top level: capacity register, clock replacement engine and output register.
// Second-chance (clock) page replacement over a table of up to 64 frames. Each
// input item is one page reference; each produces exactly one result item with
// the fault flag, the page and the frame that now holds it. One item is worked
// at a time. The frame table sits in a single-read-port memory with registered
// read, so the lookup reads and compares the occupied frames one at a time. A hit
// then finishes; a fault while the table is filling writes the next free frame;
// a fault on a full table first folds the hand back into range if capacity was
// lowered, then sweeps from the hand, clearing set reference bits, until a frame
// with a clear bit is replaced. A finished result waits in the output register
// while the next item is accepted. frames_in_use of zero acts as 1 and values
// above 64 act as 64; write it only while the block is idle.
module clock_page_replacement (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pcr_pkg::CFG_W-1:0]       cfg_wdata,  // frames_in_use
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [pcr_pkg::IN_TDATA_W-1:0]  in_tdata,   // [31:0] page_number
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [31:0] page_out, [37:32] frame_index, [39:38] zero pad
  output logic [pcr_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tuser   // fault
);

  import pcr_pkg::*;

  logic [CFG_W-1:0]        frames_in_use_r;
  logic [CNT_W-1:0]        cap;
  logic                    res_valid;
  logic                    res_ready;
  pcr_result_t             res;
  logic                    out_valid_r;
  logic [PAGE_W-1:0]       out_page_r;
  logic [FRAME_IDX_W-1:0]  out_frame_r;
  logic                    out_fault_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_in_use_r <= CFG_W'(MAX_FRAMES);
    end else if (cfg_we) begin
      frames_in_use_r <= cfg_wdata;
    end
  end

  // clamp capacity into 1..MAX_FRAMES
  always_comb begin
    if (frames_in_use_r == '0) begin
      cap = CNT_W'(1);
    end else if (int'(frames_in_use_r) > MAX_FRAMES) begin
      cap = CNT_W'(MAX_FRAMES);
    end else begin
      cap = CNT_W'(frames_in_use_r);
    end
  end

  pcr_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_page   (in_tdata[PAGE_W-1:0]),
    .cap       (cap),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_page_r  <= res.page;
      out_frame_r <= FRAME_IDX_W'(res.frame);
      out_fault_r <= res.fault;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_fault_r;
  assign out_tdata  = {{(OUT_TDATA_W - PAGE_W - FRAME_IDX_W){1'b0}}, out_frame_r, out_page_r};

endmodule

### verif/tb_top.sv
// Testbench for clock_page_replacement: directed and random page references, self-checked.
`timescale 1ns / 1ps

module tb_top;
  import pcr_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int NUM_PHASES  = 11;
  localparam int PHASE_ITEMS = 55;
  localparam int POOL_SIZE   = 80;

  // Tracks the frame table and holds the results still owed by the block.
  class clock_table_board;
    logic [PAGE_W-1:0] frame_page [MAX_FRAMES];
    bit                ref_bit    [MAX_FRAMES];
    int unsigned       filled;
    int unsigned       hand;
    logic [CFG_W-1:0]  frames_cfg;
    pcr_result_t       awaited_q[$];
    int                mismatches;

    function new();
      filled     = 0;
      hand       = 0;
      frames_cfg = 7'd64;
      mismatches = 0;
      foreach (ref_bit[i]) ref_bit[i] = 1'b0;
    endfunction

    function void set_frames(logic [CFG_W-1:0] v);
      frames_cfg = v;
    endfunction

    function int unsigned capacity();
      if (frames_cfg == 0) return 1;
      if (frames_cfg > MAX_FRAMES) return MAX_FRAMES;
      return frames_cfg;
    endfunction

    function void note_reference(logic [PAGE_W-1:0] page);
      int unsigned cap;
      int unsigned occ;
      int unsigned h;
      int unsigned frame;
      bit          hit;
      pcr_result_t res;
      cap   = capacity();
      occ   = (filled < cap) ? filled : cap;
      hit   = 1'b0;
      frame = 0;
      // first matching frame wins
      for (int i = 0; i < occ; i++) begin
        if (frame_page[i] == page) begin
          ref_bit[i] = 1'b1;
          frame      = i;
          hit        = 1'b1;
          break;
        end
      end
      if (!hit) begin
        if (filled < cap) begin
          frame  = filled;
          filled = filled + 1;
        end else begin
          // sweep: clear set bits until a clear one turns up
          h = hand % cap;
          for (int i = 0; i <= cap; i++) begin
            if (!ref_bit[h]) break;
            ref_bit[h] = 1'b0;
            h = (h + 1) % cap;
          end
          frame = h;
          hand  = (h + 1) % cap;
        end
        frame_page[frame] = page;
        ref_bit[frame]    = 1'b1;
      end
      res.fault = !hit;
      res.page  = page;
      res.frame = frame[FRAME_W-1:0];
      awaited_q = {awaited_q, res};
    endfunction

    function void check_result(logic fault, logic [PAGE_W-1:0] page,
                               logic [FRAME_W-1:0] frame, logic [1:0] pad);
      pcr_result_t want;
      if (awaited_q.size() == 0) begin
        $display("%0t: unexpected item: fault=%0b page=%h frame=%0d",
                 $time, fault, page, frame);
        mismatches++;
        return;
      end
      want = awaited_q[0];
      awaited_q.delete(0);
      if (fault !== want.fault) begin
        $display("%0t: fault mismatch: expected %0b actual %0b (page %h)",
                 $time, want.fault, fault, want.page);
        mismatches++;
      end
      if (page !== want.page) begin
        $display("%0t: page mismatch: expected %h actual %h", $time, want.page, page);
        mismatches++;
      end
      if (frame !== want.frame) begin
        $display("%0t: frame mismatch: expected %0d actual %0d (page %h)",
                 $time, want.frame, frame, want.page);
        mismatches++;
      end
      if (pad !== 2'b00) begin
        $display("%0t: tdata pad mismatch: expected 0 actual %b", $time, pad);
        mismatches++;
      end
    endfunction

    function int pending();
      return awaited_q.size();
    endfunction
  endclass

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_we     = 1'b0;
  logic [CFG_W-1:0]       cfg_wdata  = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  clock_table_board  board;
  logic [PAGE_W-1:0] page_pool [POOL_SIZE];
  int                idle_pct   = 0;
  int                stall_left = 0;
  int                cycle_count = 0;
  int unsigned       phase_cap [NUM_PHASES] = '{8, 1, 64, 3, 127, 5, 16, 0, 2, 40, 64};

  clock_page_replacement dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: stall in random bursts.
  always @(negedge clk) begin
    if (!rst_n || idle_pct == 0) begin
      stall_left = 0;
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < idle_pct / 3) begin
      stall_left = $urandom_range(1, 15) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_result(out_tuser, out_tdata[31:0], out_tdata[37:32], out_tdata[39:38]);
  end

  task automatic send_page(input logic [PAGE_W-1:0] page);
    int gap;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 15);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= page;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_reference(page);
  endtask

  // Hold the sender until every owed item has come back.
  task automatic wait_drained(input int settle);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_frames(input logic [CFG_W-1:0] v);
    wait_drained(4);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    board.set_frames(v);
  endtask

  initial begin
    int unsigned       eff;
    int unsigned       win;
    logic [PAGE_W-1:0] pg;
    board = new();
    for (int i = 0; i < POOL_SIZE; i++)
      page_pool[i] = (i % 4 == 0) ? PAGE_W'(i) : $urandom;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Reset capacity, field extremes and a hit.
    idle_pct = 20;
    send_page(32'h0000_0000);
    send_page(32'hFFFF_FFFF);
    send_page(32'h0000_0000);
    send_page(32'h0000_0001);
    send_page(32'h8000_0000);
    // Lower capacity below the fill level: frames above it drop out.
    write_frames(7'd2);
    send_page(32'hFFFF_FFFF);
    send_page(32'h0000_0001);
    send_page(32'h0000_0000);
    send_page(32'hA5A5_A5A5);
    // Zero acts as a single frame.
    write_frames(7'd0);
    send_page(32'h0000_0007);
    send_page(32'h0000_0007);
    send_page(32'h0000_0008);
    // Above the maximum: refill the upper frames, duplicates resolve low.
    write_frames(7'd127);
    send_page(32'h8000_0000);
    send_page(32'h0000_0001);
    send_page(32'h0000_0008);
    send_page(32'h5A5A_5A5A);
    send_page(32'h0000_0001);

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_frames(CFG_W'(phase_cap[p]));
      if (p == NUM_PHASES - 1 || p % 3 == 1) idle_pct = 0;
      else idle_pct = 25;
      eff = (phase_cap[p] == 0) ? 1 : ((phase_cap[p] > MAX_FRAMES) ? MAX_FRAMES : phase_cap[p]);
      win = (eff + 4 < POOL_SIZE) ? eff + 4 : POOL_SIZE;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 4 && n == PHASE_ITEMS / 2) wait_drained(0);
        if ($urandom_range(0, 99) < 15) pg = $urandom;
        else pg = page_pool[$urandom_range(0, win - 1)];
        send_page(pg);
      end
    end

    wait_drained(300);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
